// ===== rtl/trng_pkg.sv =====
// Shared types, constants and word functions of the TT800 random generator.
`default_nettype none

package trng_pkg;

    localparam int WORD_COUNT   = 25;
    localparam int WIDX_W       = 5;
    localparam int REQ_DEPTH    = 2;
    localparam int RES_DEPTH    = 2;
    localparam int DIV_STEPS    = 31;
    localparam int DIV_CNT_W    = 5;

    localparam logic [WIDX_W-1:0] LAST_WORD    = WIDX_W'(WORD_COUNT - 1);
    localparam logic [WIDX_W-1:0] TWIST_OFFSET = WIDX_W'(7);
    localparam logic [WIDX_W-1:0] TWIST_WRAP   = WIDX_W'(WORD_COUNT - 7);

    localparam logic [2:0] OP_RESEED = 3'd0;
    localparam logic [2:0] OP_DRAW32 = 3'd1;
    localparam logic [2:0] OP_DRAW31 = 3'd2;
    localparam logic [2:0] OP_DRAW64 = 3'd3;
    localparam logic [2:0] OP_SCALED = 3'd4;
    localparam logic [2:0] OP_MODULO = 3'd5;
    localparam logic [2:0] OP_RANGE  = 3'd6;

    localparam logic [31:0] SEED_RESET = 32'd1;
    localparam logic [31:0] LCG_MUL    = 32'd1313;
    localparam logic [31:0] LCG_ADD    = 32'd88897;
    localparam logic [31:0] TWIST_MASK = 32'h8ebf_d028;
    localparam logic [31:0] TEMPER_B   = 32'h2b5b_2500;
    localparam logic [31:0] TEMPER_C   = 32'hdb8b_0000;

    // Request after classification: span and its magnitude are ready for the back end.
    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] scale;
        logic signed [31:0] lower;
        logic signed [32:0] span;
        logic [31:0]        span_mag;
        logic               span_zero;
    } t_req;

    typedef struct packed {
        logic signed [32:0] value;
        logic               last;
        logic               error;
    } t_res;

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ ((w << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        return y;
    endfunction

    function automatic logic [31:0] twist(input logic [31:0] w, input logic [31:0] partner);
        return partner ^ (w >> 1) ^ (w[0] ? TWIST_MASK : 32'd0);
    endfunction

    function automatic logic [WIDX_W-1:0] partner_index(input logic [WIDX_W-1:0] i);
        return (i >= TWIST_WRAP) ? i - TWIST_WRAP : i + TWIST_OFFSET;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/trng_front.sv =====
// Front end: accepts requests, computes the span and queues them for the engine.
`default_nettype none

module trng_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    output logic                    o_full,
    input  wire logic [2:0]         i_operation,
    input  wire logic signed [31:0] i_scale_range,
    input  wire logic signed [31:0] i_lower_bound,
    input  wire logic signed [31:0] i_upper_bound,
    output trng_pkg::t_req          o_req,
    output logic                    o_req_valid,
    input  wire logic               i_req_take
);
    import trng_pkg::*;

    t_req               r_q [REQ_DEPTH];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_cnt;
    t_req               w_new;
    logic signed [32:0] w_span;
    logic signed [32:0] w_neg;
    logic               w_acc;
    logic               w_take;

    always_comb begin
        w_span          = {i_upper_bound[31], i_upper_bound} - {i_lower_bound[31], i_lower_bound};
        w_neg           = -w_span;
        w_new.op        = i_operation;
        w_new.scale     = i_scale_range;
        w_new.lower     = i_lower_bound;
        w_new.span      = w_span;
        w_new.span_mag  = w_span[32] ? w_neg[31:0] : w_span[31:0];
        w_new.span_zero = (w_span == '0);
    end

    assign o_full      = (r_cnt == 2'(REQ_DEPTH));
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rp];
    assign w_acc       = i_push && !o_full;
    assign w_take      = i_req_take && o_req_valid;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_q[r_wp] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_acc) begin
                r_wp <= ~r_wp;
            end
            if (w_take) begin
                r_rp <= ~r_rp;
            end
            case ({w_acc, w_take})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/trng_div.sv =====
// Bit-serial restoring divider that returns the remainder of a 31-bit dividend.
`default_nettype none

module trng_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [30:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_rem
);
    import trng_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [30:0]          r_dvd;
    logic [31:0]          r_dvs;
    logic [31:0]          r_rem;
    logic [32:0]          w_trial;
    logic [32:0]          w_diff;

    assign w_trial = {r_rem, r_dvd[30]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign o_done  = r_done;
    assign o_rem   = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            // subtract when the trial remainder reaches the divisor
            r_rem <= (w_trial >= {1'b0, r_dvs}) ? w_diff[31:0] : w_trial[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/trng_engine.sv =====
// Back end: word store, fill and regeneration sequencer, tempering and output forms.
`default_nettype none

module trng_engine (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [31:0]    i_cfg_wdata,
    input  wire trng_pkg::t_req i_req,
    input  wire logic           i_req_valid,
    output logic                o_req_take,
    output trng_pkg::t_res      o_res,
    output logic                o_res_valid,
    input  wire logic           i_res_ready
);
    import trng_pkg::*;

    localparam logic [3:0] S_FILL  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DRAW  = 4'd2;
    localparam logic [3:0] S_RG_RD = 4'd3;
    localparam logic [3:0] S_RG_WR = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_TEMP  = 4'd6;
    localparam logic [3:0] S_FORM  = 4'd7;
    localparam logic [3:0] S_MUL   = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_EMIT  = 4'd10;

    logic [31:0]        r_mem [WORD_COUNT];
    logic [31:0]        r_rd_a;
    logic [31:0]        r_rd_b;

    logic [3:0]         r_state, n_state;
    logic [31:0]        r_seed;
    logic [31:0]        r_lcg, n_lcg;
    logic [WIDX_W-1:0]  r_idx, n_idx;
    logic [WIDX_W-1:0]  r_wi, n_wi;
    logic               r_boot, n_boot;
    logic               r_second, n_second;
    t_req               r_req, n_req;
    logic [31:0]        r_word, n_word;
    logic signed [49:0] r_prod, n_prod;
    t_res               r_res, n_res;

    logic [WIDX_W-1:0]  w_addr_a;
    logic [WIDX_W-1:0]  w_addr_b;
    logic               w_we;
    logic [31:0]        w_wdata;
    logic signed [16:0] w_mul_a;
    logic signed [32:0] w_mul_b;
    logic signed [49:0] w_prod;
    logic signed [33:0] w_addend;
    logic signed [33:0] w_scaled;
    logic signed [33:0] w_modsum;
    logic               w_div_start;
    logic               w_div_done;
    logic [31:0]        w_div_rem;

    trng_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_word[30:0]),
        .i_divisor  (r_req.span_mag),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    assign w_addr_a = (r_state == S_RG_RD) ? r_wi : r_idx;
    assign w_addr_b = partner_index(r_wi);
    assign w_we     = (r_state == S_FILL) || (r_state == S_RG_WR);
    assign w_wdata  = (r_state == S_FILL) ? r_lcg : twist(r_rd_a, r_rd_b);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_wi] <= w_wdata;
        end
        r_rd_a <= r_mem[w_addr_a];
        r_rd_b <= r_mem[w_addr_b];
    end

    // Low 16 bits of the word times either the scale or the span; floor by arithmetic shift.
    assign w_mul_a  = {1'b0, r_word[15:0]};
    assign w_mul_b  = (r_req.op == OP_SCALED) ? {r_req.scale[31], r_req.scale} : r_req.span;
    assign w_prod   = w_mul_a * w_mul_b;
    assign w_addend = (r_req.op == OP_RANGE) ? {{2{r_req.lower[31]}}, r_req.lower} : 34'sd0;
    assign w_scaled = r_prod[49:16] + w_addend;
    assign w_modsum = {{2{r_req.lower[31]}}, r_req.lower} + {2'b00, w_div_rem};

    assign o_req_take  = (r_state == S_IDLE) && i_req_valid;
    assign o_res_valid = (r_state == S_EMIT);
    assign o_res       = r_res;
    assign w_div_start = (r_state == S_FORM) && (r_req.op == OP_MODULO) && !r_req.span_zero;

    always_comb begin
        n_state  = r_state;
        n_lcg    = r_lcg;
        n_idx    = r_idx;
        n_wi     = r_wi;
        n_boot   = r_boot;
        n_second = r_second;
        n_req    = r_req;
        n_word   = r_word;
        n_prod   = r_prod;
        n_res    = r_res;
        case (r_state)
            S_FILL: begin
                n_lcg = 32'(r_lcg * LCG_MUL + LCG_ADD);
                n_wi  = r_wi + WIDX_W'(1);
                if (r_wi == LAST_WORD) begin
                    n_idx = LAST_WORD;
                    if (r_boot) begin
                        n_boot  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_res   = '{value: '0, last: 1'b1, error: 1'b0};
                        n_state = S_EMIT;
                    end
                end
            end
            S_IDLE: begin
                n_second = 1'b0;
                if (i_req_valid) begin
                    n_req = i_req;
                    case (i_req.op)
                        OP_RESEED: begin
                            n_lcg   = r_seed;
                            n_wi    = '0;
                            n_state = S_FILL;
                        end
                        OP_DRAW32, OP_DRAW31, OP_DRAW64, OP_SCALED, OP_MODULO, OP_RANGE: begin
                            n_state = S_DRAW;
                        end
                        default: begin
                            n_res   = '{value: '0, last: 1'b1, error: 1'b0};
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_DRAW: begin
                if (r_idx == LAST_WORD) begin
                    n_wi    = '0;
                    n_state = S_RG_RD;
                end else begin
                    n_idx   = r_idx + WIDX_W'(1);
                    n_state = S_RD;
                end
            end
            S_RG_RD: begin
                n_state = S_RG_WR;
            end
            S_RG_WR: begin
                n_wi = r_wi + WIDX_W'(1);
                if (r_wi == LAST_WORD) begin
                    n_idx   = '0;
                    n_state = S_RD;
                end else begin
                    n_state = S_RG_RD;
                end
            end
            S_RD: begin
                n_state = S_TEMP;
            end
            S_TEMP: begin
                n_word  = temper(r_rd_a);
                n_state = S_FORM;
            end
            S_FORM: begin
                n_state = S_EMIT;
                case (r_req.op)
                    OP_DRAW32: n_res = '{value: {1'b0, r_word}, last: 1'b1, error: 1'b0};
                    OP_DRAW31: n_res = '{value: {2'b00, r_word[30:0]}, last: 1'b1, error: 1'b0};
                    OP_DRAW64: n_res = '{value: {1'b0, r_word}, last: r_second, error: 1'b0};
                    OP_SCALED, OP_RANGE: begin
                        n_prod  = w_prod;
                        n_state = S_MUL;
                    end
                    OP_MODULO: begin
                        if (r_req.span_zero) begin
                            n_res = '{value: '0, last: 1'b1, error: 1'b1};
                        end else begin
                            n_state = S_DIV;
                        end
                    end
                    default: n_res = '{value: '0, last: 1'b1, error: 1'b0};
                endcase
            end
            S_MUL: begin
                n_res   = '{value: w_scaled[32:0], last: 1'b1, error: 1'b0};
                n_state = S_EMIT;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_res   = '{value: w_modsum[32:0], last: 1'b1, error: 1'b0};
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_res_ready) begin
                    // first half of a 64-bit request: go back for the second half
                    if ((r_req.op == OP_DRAW64) && !r_res.last) begin
                        n_second = 1'b1;
                        n_state  = S_DRAW;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_word <= n_word;
        r_prod <= n_prod;
        r_res  <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_FILL;
            r_seed   <= SEED_RESET;
            r_lcg    <= SEED_RESET;
            r_idx    <= LAST_WORD;
            r_wi     <= '0;
            r_boot   <= 1'b1;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_lcg    <= n_lcg;
            r_idx    <= n_idx;
            r_wi     <= n_wi;
            r_boot   <= n_boot;
            r_second <= n_second;
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tt800_random_generator.sv =====
// Top level of the TT800 random generator: front end, engine and result queue.
`default_nettype none

// TT800 twisted GFSR generator with a queue interface on both sides. Requests are
// taken into a two-entry queue and run one at a time by the engine; results leave
// through a two-entry queue, so a waiting result does not block new requests.
// After reset the 25-word store is filled from seed 1 before the first request
// runs. A plain draw (32-bit, 31-bit, each half of a 64-bit draw) passes through
// the index step, the registered store read, tempering and output forming; the
// scaled and range forms add a multiplier state. Every 25th draw first
// regenerates the whole store, reading and writing each word in turn. The modulo
// form waits for the one-bit-per-cycle remainder unit unless the span is zero.
// A reseed refills the store from the configured seed.
module tt800_random_generator (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [31:0]        i_cfg_wdata,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [2:0]         i_operation,
    input  wire logic signed [31:0] i_scale_range,
    input  wire logic signed [31:0] i_lower_bound,
    input  wire logic signed [31:0] i_upper_bound,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [32:0]      o_value,
    output logic                    o_last,
    output logic                    o_error
);
    import trng_pkg::*;

    t_req       w_req;
    logic       w_req_valid;
    logic       w_req_take;
    t_res       w_res;
    logic       w_res_valid;
    logic       w_res_ready;
    logic       w_push;
    logic       w_pop;

    t_res       r_oq [RES_DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    trng_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_operation   (i_operation),
        .i_scale_range (i_scale_range),
        .i_lower_bound (i_lower_bound),
        .i_upper_bound (i_upper_bound),
        .o_req         (w_req),
        .o_req_valid   (w_req_valid),
        .i_req_take    (w_req_take)
    );

    trng_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (w_req),
        .i_req_valid (w_req_valid),
        .o_req_take  (w_req_take),
        .o_res       (w_res),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready)
    );

    assign w_res_ready = (r_cnt != 2'(RES_DEPTH));
    assign w_push      = w_res_valid && w_res_ready;
    assign empty       = (r_cnt == 2'd0);
    assign w_pop       = pop && !empty;
    assign o_value     = r_oq[r_rp].value;
    assign o_last      = r_oq[r_rp].last;
    assign o_error     = r_oq[r_rp].error;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_oq[r_wp] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_error_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_error |-> (o_value == '0) && o_last)
        else $error("error result carries a nonzero value or is not last");

    a_first_half_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_last |-> !o_error)
        else $error("first half of a 64-bit request flags an error");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_halves_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_res.last |=> !(w_push && !w_res.last))
        else $error("two first halves queued on consecutive cycles");

endmodule

`default_nettype wire
